/* hdl/fifo_reader_writer_lock_defines.svh */
// ---------------------------------------------------------------------------
// fifo_reader_writer_lock assertion macros
// shared assertion forms, clocked on clk and disabled during rst
// ---------------------------------------------------------------------------
`ifndef FIFO_READER_WRITER_LOCK_DEFINES_SVH
`define FIFO_READER_WRITER_LOCK_DEFINES_SVH

// property must hold at every clock edge out of reset
`define FRWL_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// condition must never be seen at a clock edge out of reset
`define FRWL_NEVER(label, cond, msg) \
  `FRWL_ASSERT(label, !(cond), msg)

`endif

/* hdl/frwl_pkg.sv */
// ---------------------------------------------------------------------------
// frwl_pkg
// shared sizes, codes and helpers of the reader-writer lock manager
// ---------------------------------------------------------------------------
package frwl_pkg;

  // sizes
  localparam int QUEUE_DEPTH  = 16;
  localparam int PROC_ID_BITS = 8;
  localparam int IDX_W        = $clog2(QUEUE_DEPTH);
  localparam int CNT_W        = $clog2(QUEUE_DEPTH + 1);
  localparam int ENTRY_W      = PROC_ID_BITS + 1;
  localparam int OP_W         = 3;
  localparam int KIND_W       = 3;
  localparam int PID_PORT_W   = 8;
  localparam int RC_W         = 9;

  typedef logic [IDX_W-1:0]        idx_t;
  typedef logic [CNT_W-1:0]        cnt_t;
  typedef logic [ENTRY_W-1:0]      entry_t;
  typedef logic [PROC_ID_BITS-1:0] pid_t;
  typedef logic [RC_W-1:0]         rcount_t;

  localparam rcount_t READERS_MAX = '1;

  // request operations
  localparam logic [OP_W-1:0] OP_READ_LOCK    = 3'd0;
  localparam logic [OP_W-1:0] OP_READ_UNLOCK  = 3'd1;
  localparam logic [OP_W-1:0] OP_WRITE_LOCK   = 3'd2;
  localparam logic [OP_W-1:0] OP_WRITE_UNLOCK = 3'd3;
  localparam logic [OP_W-1:0] OP_TRY_READ     = 3'd4;

  // result kinds
  localparam logic [KIND_W-1:0] K_GRANTED  = 3'd0;
  localparam logic [KIND_W-1:0] K_QUEUED   = 3'd1;
  localparam logic [KIND_W-1:0] K_TRYFAIL  = 3'd2;
  localparam logic [KIND_W-1:0] K_RELEASED = 3'd3;
  localparam logic [KIND_W-1:0] K_WOKEN    = 3'd4;
  localparam logic [KIND_W-1:0] K_ERROR    = 3'd5;

  // queue index step with wrap at the queue depth
  function automatic idx_t idx_inc(input idx_t i);
    idx_t r;
    if (i == idx_t'(QUEUE_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = i + idx_t'(1);
    end
    return r;
  endfunction

endpackage

/* hdl/frwl_wait_ram.sv */
// ---------------------------------------------------------------------------
// frwl_wait_ram
// waiter queue storage: one write port, one read port, registered read data
// ---------------------------------------------------------------------------
module frwl_wait_ram (
  input  logic             clk,
  input  logic             we,
  input  frwl_pkg::idx_t   waddr,
  input  frwl_pkg::entry_t wdata,
  input  frwl_pkg::idx_t   raddr,
  output frwl_pkg::entry_t rdata
);

  frwl_pkg::entry_t mem [frwl_pkg::QUEUE_DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, registered read data
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

/* hdl/fifo_reader_writer_lock.sv */
// ---------------------------------------------------------------------------
// fifo_reader_writer_lock
// reader-writer lock manager with a fifo of waiting processes
// ---------------------------------------------------------------------------
// Flow: a request is taken in S_IDLE and decided in S_EXEC; its result is then
//   registered onto strobe. One request at a time: busy stays high until the
//   last result is decided. A write unlock waking a run of readers first scans
//   the run in the queue memory, then does one memory read per woken reader.
// The receiver cannot stall: each result shows for one cycle with strobe.
// Reset (rst, synchronous): lock free, queue empty; queue memory not cleared.

`include "fifo_reader_writer_lock_defines.svh"

module fifo_reader_writer_lock (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic [2:0] op,
  input  logic [7:0] proc_id,
  output logic       strobe,
  output logic [2:0] kind,
  output logic [7:0] who,
  output logic       last,
  output logic [8:0] reader_count,
  output logic       writer_held
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;
  localparam logic [1:0] S_WAKE = 2'd3;

  logic [1:0]                           state, state_next;
  logic [frwl_pkg::OP_W-1:0]            op_r;
  frwl_pkg::pid_t                       id_r;
  frwl_pkg::rcount_t                    readers_held, readers_held_next;
  logic                                 writer_flag, writer_flag_next;
  frwl_pkg::idx_t                       queue_head, queue_head_next;
  frwl_pkg::idx_t                       queue_tail, queue_tail_next;
  frwl_pkg::cnt_t                       queue_count, queue_count_next;
  frwl_pkg::cnt_t                       run, run_next;
  frwl_pkg::idx_t                       scan_ptr, scan_ptr_next;

  logic                                 res_valid;
  logic [frwl_pkg::KIND_W-1:0]          res_kind;
  frwl_pkg::pid_t                       res_who;
  logic                                 res_last;

  logic                                 mem_we;
  frwl_pkg::idx_t                       mem_waddr;
  frwl_pkg::entry_t                     mem_wdata;
  frwl_pkg::idx_t                       mem_raddr;
  frwl_pkg::entry_t                     mem_rdata;

  logic                                 accept;
  logic                                 head_writer;
  frwl_pkg::pid_t                       head_id;
  logic [frwl_pkg::RC_W:0]              woken_sum;

  assign busy        = (state != S_IDLE);
  assign accept      = start && !busy;
  assign head_writer = mem_rdata[frwl_pkg::PROC_ID_BITS];
  assign head_id     = mem_rdata[frwl_pkg::PROC_ID_BITS-1:0];
  assign woken_sum   = {1'b0, readers_held} + (frwl_pkg::RC_W + 1)'(run);

  // waiter queue memory
  frwl_wait_ram u_wait_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // request decode and queue sequencing
  always_comb begin
    state_next        = state;
    readers_held_next = readers_held;
    writer_flag_next  = writer_flag;
    queue_head_next   = queue_head;
    queue_tail_next   = queue_tail;
    queue_count_next  = queue_count;
    run_next          = run;
    scan_ptr_next     = scan_ptr;
    res_valid         = 1'b0;
    res_kind          = frwl_pkg::K_ERROR;
    res_who           = id_r;
    res_last          = 1'b1;
    mem_we            = 1'b0;
    mem_waddr         = queue_tail;
    mem_wdata         = {1'b0, id_r};
    mem_raddr         = queue_head;

    unique case (state)
      S_IDLE: begin
        // head entry is fetched while the request is taken
        mem_raddr = queue_head;
        if (accept) begin
          state_next = S_EXEC;
        end
      end

      S_EXEC: begin
        res_valid  = 1'b1;
        state_next = S_IDLE;
        mem_raddr  = frwl_pkg::idx_inc(queue_head);
        unique case (op_r)
          frwl_pkg::OP_READ_LOCK, frwl_pkg::OP_TRY_READ: begin
            if (!writer_flag && queue_count == '0) begin
              if (readers_held == frwl_pkg::READERS_MAX) begin
                res_kind = frwl_pkg::K_ERROR;
              end else begin
                readers_held_next = readers_held + frwl_pkg::rcount_t'(1);
                res_kind          = frwl_pkg::K_GRANTED;
              end
            end else if (op_r == frwl_pkg::OP_TRY_READ) begin
              res_kind = frwl_pkg::K_TRYFAIL;
            end else if (queue_count == frwl_pkg::cnt_t'(frwl_pkg::QUEUE_DEPTH)) begin
              res_kind = frwl_pkg::K_ERROR;
            end else begin
              mem_we           = 1'b1;
              mem_wdata        = {1'b0, id_r};
              queue_tail_next  = frwl_pkg::idx_inc(queue_tail);
              queue_count_next = queue_count + frwl_pkg::cnt_t'(1);
              res_kind         = frwl_pkg::K_QUEUED;
            end
          end

          frwl_pkg::OP_READ_UNLOCK: begin
            if (readers_held == '0) begin
              res_kind = frwl_pkg::K_ERROR;
            end else if (readers_held != frwl_pkg::rcount_t'(1) || queue_count == '0) begin
              readers_held_next = readers_held - frwl_pkg::rcount_t'(1);
              res_kind          = frwl_pkg::K_RELEASED;
            end else if (!head_writer) begin
              res_kind = frwl_pkg::K_ERROR;
            end else begin
              // last reader out hands the lock to the waiting writer
              readers_held_next = '0;
              writer_flag_next  = 1'b1;
              queue_head_next   = frwl_pkg::idx_inc(queue_head);
              queue_count_next  = queue_count - frwl_pkg::cnt_t'(1);
              res_kind          = frwl_pkg::K_WOKEN;
              res_who           = head_id;
            end
          end

          frwl_pkg::OP_WRITE_LOCK: begin
            if (readers_held == '0 && !writer_flag) begin
              writer_flag_next = 1'b1;
              res_kind         = frwl_pkg::K_GRANTED;
            end else if (queue_count == frwl_pkg::cnt_t'(frwl_pkg::QUEUE_DEPTH)) begin
              res_kind = frwl_pkg::K_ERROR;
            end else begin
              mem_we           = 1'b1;
              mem_wdata        = {1'b1, id_r};
              queue_tail_next  = frwl_pkg::idx_inc(queue_tail);
              queue_count_next = queue_count + frwl_pkg::cnt_t'(1);
              res_kind         = frwl_pkg::K_QUEUED;
            end
          end

          frwl_pkg::OP_WRITE_UNLOCK: begin
            if (!writer_flag) begin
              res_kind = frwl_pkg::K_ERROR;
            end else if (queue_count == '0) begin
              writer_flag_next = 1'b0;
              res_kind         = frwl_pkg::K_RELEASED;
            end else if (head_writer) begin
              queue_head_next  = frwl_pkg::idx_inc(queue_head);
              queue_count_next = queue_count - frwl_pkg::cnt_t'(1);
              res_kind         = frwl_pkg::K_WOKEN;
              res_who          = head_id;
            end else begin
              // reader at head: measure the run of readers first
              res_valid     = 1'b0;
              run_next      = frwl_pkg::cnt_t'(1);
              scan_ptr_next = frwl_pkg::idx_inc(queue_head);
              state_next    = S_SCAN;
            end
          end

          default: begin
            res_kind = frwl_pkg::K_ERROR;
          end
        endcase
      end

      S_SCAN: begin
        // read data is the entry at scan_ptr
        if (run < queue_count && !head_writer) begin
          run_next      = run + frwl_pkg::cnt_t'(1);
          scan_ptr_next = frwl_pkg::idx_inc(scan_ptr);
          mem_raddr     = frwl_pkg::idx_inc(scan_ptr);
        end else begin
          // run known: settle the final lock state, then wake one by one
          if (woken_sum > (frwl_pkg::RC_W + 1)'(frwl_pkg::READERS_MAX)) begin
            readers_held_next = frwl_pkg::READERS_MAX;
          end else begin
            readers_held_next = woken_sum[frwl_pkg::RC_W-1:0];
          end
          writer_flag_next = 1'b0;
          mem_raddr        = queue_head;
          state_next       = S_WAKE;
        end
      end

      S_WAKE: begin
        // read data is the head entry
        res_valid        = 1'b1;
        res_kind         = frwl_pkg::K_WOKEN;
        res_who          = head_id;
        res_last         = (run == frwl_pkg::cnt_t'(1));
        queue_head_next  = frwl_pkg::idx_inc(queue_head);
        queue_count_next = queue_count - frwl_pkg::cnt_t'(1);
        run_next         = run - frwl_pkg::cnt_t'(1);
        mem_raddr        = frwl_pkg::idx_inc(queue_head);
        if (run == frwl_pkg::cnt_t'(1)) begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      readers_held <= '0;
      writer_flag  <= 1'b0;
      queue_head   <= '0;
      queue_tail   <= '0;
      queue_count  <= '0;
      run          <= '0;
      strobe       <= 1'b0;
    end else begin
      state        <= state_next;
      readers_held <= readers_held_next;
      writer_flag  <= writer_flag_next;
      queue_head   <= queue_head_next;
      queue_tail   <= queue_tail_next;
      queue_count  <= queue_count_next;
      run          <= run_next;
      strobe       <= res_valid;
    end
  end

  // request capture, scan pointer and result payload
  always_ff @(posedge clk) begin
    scan_ptr <= scan_ptr_next;
    if (accept) begin
      op_r <= op;
      id_r <= proc_id[frwl_pkg::PROC_ID_BITS-1:0];
    end
    if (res_valid) begin
      kind         <= res_kind;
      who          <= frwl_pkg::PID_PORT_W'(res_who);
      last         <= res_last;
      reader_count <= readers_held_next;
      writer_held  <= writer_flag_next;
    end
  end

  // checks
  `FRWL_NEVER(a_queue_bound, queue_count > frwl_pkg::cnt_t'(frwl_pkg::QUEUE_DEPTH), "queue count beyond depth")
  `FRWL_NEVER(a_writer_excl, writer_flag && readers_held != '0, "writer and readers hold the lock")
  `FRWL_NEVER(a_wake_run, state == S_WAKE && (run == '0 || run > queue_count), "wake run out of range")
  `FRWL_ASSERT(a_accept_exec, accept |=> state == S_EXEC, "accepted request not executed")

endmodule

/* bench/fifo_reader_writer_lock_checker.sv */
// ---------------------------------------------------------------------------
// fifo_reader_writer_lock_checker
// watches the request and result channels of the lock manager, predicts the
// results of every accepted request and compares them in arrival order
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module fifo_reader_writer_lock_checker
  import frwl_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic       busy,
  input  logic [2:0] op,
  input  logic [7:0] proc_id,
  input  logic       strobe,
  input  logic [2:0] kind,
  input  logic [7:0] who,
  input  logic       last,
  input  logic [8:0] reader_count,
  input  logic       writer_held,
  output int         mismatches,
  output int         compared,
  output int         outstanding
);

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [7:0]        who;
    logic              last;
    rcount_t           readers;
    logic              writer;
  } lock_result_t;

  // shadow of the lock state
  rcount_t readers_now;
  logic    writer_now;
  entry_t  waiters [QUEUE_DEPTH];
  idx_t    wait_head;
  idx_t    wait_tail;
  cnt_t    wait_count;

  lock_result_t awaited_results [$];
  lock_result_t oldest;

  // append a waiter, false when the queue is already full
  function automatic bit join_queue(input entry_t entry);
    bit ok;
    ok = (wait_count < cnt_t'(QUEUE_DEPTH));
    if (ok) begin
      waiters[wait_tail] = entry;
      wait_tail = wait_tail + idx_t'(1);
      wait_count = wait_count + cnt_t'(1);
    end
    return ok;
  endfunction

  // remove the head waiter and give its process id
  function automatic pid_t leave_queue();
    entry_t entry;
    entry = waiters[wait_head];
    wait_head = wait_head + idx_t'(1);
    wait_count = wait_count - cnt_t'(1);
    return entry[PROC_ID_BITS-1:0];
  endfunction

  function automatic bit head_is_writer();
    return waiters[wait_head][PROC_ID_BITS];
  endfunction

  // grant, queue, release or hand over the lock for one request
  task automatic grant_and_wake(input logic [2:0] req_op, input logic [7:0] req_pid);
    logic [KIND_W-1:0] kinds [0:QUEUE_DEPTH];
    pid_t              whos  [0:QUEUE_DEPTH];
    pid_t              id;
    int                n;
    lock_result_t      r;
    id = req_pid[PROC_ID_BITS-1:0];
    n = 0;
    case (req_op)
      OP_READ_LOCK, OP_TRY_READ: begin
        if (!writer_now && wait_count == '0) begin
          if (readers_now == READERS_MAX) begin
            kinds[n] = K_ERROR;
          end else begin
            readers_now = readers_now + rcount_t'(1);
            kinds[n] = K_GRANTED;
          end
        end else if (req_op == OP_TRY_READ) begin
          kinds[n] = K_TRYFAIL;
        end else begin
          kinds[n] = join_queue({1'b0, id}) ? K_QUEUED : K_ERROR;
        end
        whos[n] = id;
        n++;
      end
      OP_READ_UNLOCK: begin
        if (readers_now == '0) begin
          kinds[n] = K_ERROR;
          whos[n] = id;
        end else if (readers_now > rcount_t'(1) || wait_count == '0) begin
          readers_now = readers_now - rcount_t'(1);
          kinds[n] = K_RELEASED;
          whos[n] = id;
        end else if (!head_is_writer()) begin
          kinds[n] = K_ERROR;
          whos[n] = id;
        end else begin
          // last reader leaves, the head writer takes over
          readers_now = '0;
          writer_now = 1'b1;
          kinds[n] = K_WOKEN;
          whos[n] = leave_queue();
        end
        n++;
      end
      OP_WRITE_LOCK: begin
        if (readers_now == '0 && !writer_now) begin
          writer_now = 1'b1;
          kinds[n] = K_GRANTED;
        end else begin
          kinds[n] = join_queue({1'b1, id}) ? K_QUEUED : K_ERROR;
        end
        whos[n] = id;
        n++;
      end
      OP_WRITE_UNLOCK: begin
        if (!writer_now) begin
          kinds[n] = K_ERROR;
          whos[n] = id;
          n++;
        end else if (wait_count == '0) begin
          writer_now = 1'b0;
          kinds[n] = K_RELEASED;
          whos[n] = id;
          n++;
        end else if (head_is_writer()) begin
          kinds[n] = K_WOKEN;
          whos[n] = leave_queue();
          n++;
        end else begin
          // wake the whole leading run of readers
          while (wait_count != '0 && !head_is_writer() && n < QUEUE_DEPTH) begin
            if (readers_now != READERS_MAX) begin
              readers_now = readers_now + rcount_t'(1);
            end
            kinds[n] = K_WOKEN;
            whos[n] = leave_queue();
            n++;
          end
          writer_now = 1'b0;
        end
      end
      default: begin
        kinds[n] = K_ERROR;
        whos[n] = id;
        n++;
      end
    endcase
    // every result of a step carries the state after the whole step
    for (int k = 0; k < n; k++) begin
      r.kind    = kinds[k];
      r.who     = 8'(whos[k]);
      r.last    = (k == n - 1);
      r.readers = readers_now;
      r.writer  = writer_now;
      awaited_results.push_back(r);
    end
  endtask

  task automatic check_field(input string name, input int unsigned expv,
                             input int unsigned actv);
    if (expv != actv) begin
      $error("%s mismatch: expected %0d, actual %0d", name, expv, actv);
      mismatches++;
    end
  endtask

  // compare results first, then predict the request of this edge
  always @(posedge clk) begin
    if (rst) begin
      readers_now = '0;
      writer_now  = 1'b0;
      wait_head   = '0;
      wait_tail   = '0;
      wait_count  = '0;
      awaited_results.delete();
      mismatches  = 0;
      compared    = 0;
    end else begin
      if (strobe) begin
        if (awaited_results.size() == 0) begin
          $error("unexpected result: kind %0d who %0d last %0d", kind, who, last);
          mismatches++;
        end else begin
          oldest = awaited_results.pop_front();
          check_field("kind", oldest.kind, kind);
          check_field("who", oldest.who, who);
          check_field("last", oldest.last, last);
          check_field("reader_count", oldest.readers, reader_count);
          check_field("writer_held", oldest.writer, writer_held);
          compared++;
        end
      end
      if (start && !busy) begin
        grant_and_wake(op, proc_id);
      end
    end
    outstanding <= awaited_results.size();
  end

endmodule

/* bench/fifo_reader_writer_lock_tb.sv */
// ---------------------------------------------------------------------------
// fifo_reader_writer_lock_tb
// drives lock requests into the manager: a directed pass over the error and
// hand-over cases, then random bursts of queue-filling and mixed traffic
// under several sender idling rates
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module fifo_reader_writer_lock_tb;
  import frwl_pkg::*;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       start = 1'b0;
  logic [2:0] op = OP_READ_LOCK;
  logic [7:0] proc_id = 8'd0;
  logic       busy;
  logic       strobe;
  logic [2:0] kind;
  logic [7:0] who;
  logic       last;
  logic [8:0] reader_count;
  logic       writer_held;

  int mismatches;
  int compared;
  int outstanding;
  int sent = 0;
  int sender_idle_pct = 0;

  fifo_reader_writer_lock dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .op           (op),
    .proc_id      (proc_id),
    .strobe       (strobe),
    .kind         (kind),
    .who          (who),
    .last         (last),
    .reader_count (reader_count),
    .writer_held  (writer_held)
  );

  fifo_reader_writer_lock_checker lock_check (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .op           (op),
    .proc_id      (proc_id),
    .strobe       (strobe),
    .kind         (kind),
    .who          (who),
    .last         (last),
    .reader_count (reader_count),
    .writer_held  (writer_held),
    .mismatches   (mismatches),
    .compared     (compared),
    .outstanding  (outstanding)
  );

  // clock
  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic [7:0] any_pid();
    return 8'($urandom_range(0, 255));
  endfunction

  // one request transfer, with random idle cycles ahead of it
  task automatic issue_request(input logic [2:0] req_op, input logic [7:0] req_pid);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start   <= 1'b1;
    op      <= req_op;
    proc_id <= req_pid;
    @(posedge clk);
    while (busy) begin
      @(posedge clk);
    end
    sent++;
  endtask

  // hold requests off until every predicted result has come out
  task automatic wait_for_results();
    start <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) begin
      @(posedge clk);
    end
  endtask

  // a writer takes the lock, waiters pile up behind it, then unlocks drain it
  task automatic writer_pile();
    int n;
    int pick;
    issue_request(OP_WRITE_LOCK, any_pid());
    n = $urandom_range(1, 18);
    repeat (n) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        issue_request(OP_READ_LOCK, any_pid());
      end else if (pick < 85) begin
        issue_request(OP_WRITE_LOCK, any_pid());
      end else begin
        issue_request(OP_TRY_READ, any_pid());
      end
    end
    repeat (n + 3) begin
      issue_request($urandom_range(0, 1) ? OP_WRITE_UNLOCK : OP_READ_UNLOCK, any_pid());
    end
  endtask

  // short run of weighted random requests, unknown codes included
  task automatic random_mix();
    int pick;
    logic [2:0] req_op;
    repeat (6) begin
      pick = $urandom_range(0, 99);
      if (pick < 25) begin
        req_op = OP_READ_LOCK;
      end else if (pick < 45) begin
        req_op = OP_READ_UNLOCK;
      end else if (pick < 65) begin
        req_op = OP_WRITE_LOCK;
      end else if (pick < 85) begin
        req_op = OP_WRITE_UNLOCK;
      end else if (pick < 95) begin
        req_op = OP_TRY_READ;
      end else begin
        req_op = 3'($urandom_range(5, 7));
      end
      issue_request(req_op, any_pid());
    end
  endtask

  task automatic random_phase(input int idle_pct, input int count);
    int target;
    sender_idle_pct = idle_pct;
    target = sent + count;
    while (sent < target) begin
      if ($urandom_range(0, 99) < 40) begin
        writer_pile();
      end else begin
        random_mix();
      end
    end
    wait_for_results();
  endtask

  // stimulus and verdict
  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: errors on an idle lock, unknown codes
    issue_request(OP_READ_UNLOCK, 8'h01);
    issue_request(OP_WRITE_UNLOCK, 8'h02);
    issue_request(3'd5, 8'h00);
    issue_request(3'd6, 8'hFF);
    issue_request(3'd7, 8'hAA);
    // directed: shared grants, a waiting writer, queued and failed readers
    issue_request(OP_READ_LOCK, 8'h00);
    issue_request(OP_TRY_READ, 8'hFF);
    issue_request(OP_WRITE_LOCK, 8'h5A);
    issue_request(OP_READ_LOCK, 8'h11);
    issue_request(OP_TRY_READ, 8'h22);
    // directed: last reader hands over to the head writer
    issue_request(OP_READ_UNLOCK, 8'h00);
    issue_request(OP_READ_UNLOCK, 8'hFF);
    // directed: write unlock wakes a run of readers stopping at a writer
    issue_request(OP_READ_LOCK, 8'h33);
    issue_request(OP_READ_LOCK, 8'h44);
    issue_request(OP_WRITE_LOCK, 8'h55);
    issue_request(OP_READ_LOCK, 8'h66);
    issue_request(OP_WRITE_UNLOCK, 8'h5A);
    issue_request(OP_READ_UNLOCK, 8'h11);
    issue_request(OP_READ_UNLOCK, 8'h33);
    issue_request(OP_READ_UNLOCK, 8'h44);
    issue_request(OP_WRITE_LOCK, 8'h77);
    issue_request(OP_WRITE_UNLOCK, 8'h55);
    issue_request(OP_READ_UNLOCK, 8'h66);
    issue_request(OP_WRITE_UNLOCK, 8'h77);
    // directed: plain writer grant, try-read against it, release
    issue_request(OP_WRITE_LOCK, 8'h80);
    issue_request(OP_TRY_READ, 8'h7F);
    issue_request(OP_WRITE_UNLOCK, 8'h80);
    wait_for_results();

    // random traffic under each idling rate
    random_phase(0, 100);
    random_phase(76, 100);
    random_phase(28, 100);
    random_phase(0, 100);

    // let any stray result show up
    repeat (40) @(posedge clk);

    $display("covered %0d requests: error cases, hand-overs, reader run wakeups,", sent);
    $display("queue overflow bursts under several idling rates; %0d results compared",
             compared);
    if (mismatches == 0 && outstanding == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5ms;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

/* filelist.f */
+incdir+hdl
hdl/frwl_pkg.sv
hdl/frwl_wait_ram.sv
hdl/fifo_reader_writer_lock.sv
bench/fifo_reader_writer_lock_checker.sv
bench/fifo_reader_writer_lock_tb.sv
